// ===== rtl/arc_pkg.sv =====
// arc_pkg: shared types and constants for the adaptive replacement cache directory
// no dependencies; used by arc_if, arc_ctrl, arc_dp and the top level
package arc_pkg;

	localparam int KEY_W = 32;
	localparam int CAP_W = 5;
	localparam int LEN_W = 9;
	localparam int NLIST = 4;

	typedef enum logic [1:0] {
		L_T1,
		L_T2,
		L_B1,
		L_B2
	} list_t;

	typedef enum logic [2:0] {
		FND_NONE = 3'd0,
		FND_T1   = 3'd1,
		FND_T2   = 3'd2,
		FND_B1   = 3'd3,
		FND_B2   = 3'd4
	} found_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SEARCH,
		OP_REMOVE,
		OP_PUSH_KEY,
		OP_DEMOTE_T1,
		OP_DEMOTE_T2,
		OP_DROP_LRU,
		OP_EVICT_T1,
		OP_DIV_START,
		OP_DIV_STEP,
		OP_P_UP,
		OP_P_DOWN,
		OP_RESULT
	} dp_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SEARCH,
		S_DECIDE,
		S_DROP_B1,
		S_DROP_B2,
		S_EVICT,
		S_DIV_START,
		S_DIV,
		S_PUPD,
		S_REPL,
		S_REMOVE,
		S_PUSH,
		S_RESULT
	} ctrl_state_t;

	typedef struct packed {
		dp_op_t op;
		list_t  lst;
	} dp_cmd_t;

	typedef struct packed {
		logic [NLIST-1:0][LEN_W-1:0] len;
		logic [CAP_W-1:0]            p;
		logic [CAP_W-1:0]            cap;
		found_t                      fcode;
		logic                        search_last;
		logic                        div_busy;
		logic                        out_busy;
	} dp_stat_t;

endpackage

// ===== rtl/arc_if.sv =====
// arc_if: request, result and configuration channels of the cache directory
// depends on arc_pkg for field widths
interface arc_req_if;
	logic                       valid;
	logic                       ready;
	logic [arc_pkg::KEY_W-1:0]  page_key;
	modport source (output valid, page_key, input ready);
	modport sink (input valid, page_key, output ready);
endinterface

interface arc_rsp_if;
	logic                       valid;
	logic                       ready;
	logic                       hit;
	logic [2:0]                 found_list;
	logic                       evicted_valid;
	logic [arc_pkg::KEY_W-1:0]  evicted_page;
	logic [arc_pkg::CAP_W-1:0]  target_t1_size;
	logic [arc_pkg::CAP_W-1:0]  resident_count;
	modport source (output valid, hit, found_list, evicted_valid, evicted_page,
		target_t1_size, resident_count, input ready);
	modport sink (input valid, hit, found_list, evicted_valid, evicted_page,
		target_t1_size, resident_count, output ready);
endinterface

interface arc_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [arc_pkg::CAP_W-1:0]  capacity_in_use;
	modport source (output valid, capacity_in_use, input ready);
	modport sink (input valid, capacity_in_use, output ready);
endinterface

// ===== rtl/adaptive_replacement_cache_policy.sv =====
// adaptive replacement cache directory, one page request at a time
// a load step and a search pass over all MAX_PAGES slots, then drop, evict, demote,
// remove and push steps; a ghost hit also runs the bit-serial divider for the target
// a next request is taken in the idle state entered as the result register loads;
// the result step waits only while the previous result is still unread
// reset: all lists empty, target zero, capacity 16 (clamped to MAX_PAGES)
module adaptive_replacement_cache_policy #(
	parameter int MAX_PAGES = 16,
	parameter int KEY_BITS  = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	arc_req_if.sink    req,
	arc_rsp_if.source  rsp,
	arc_cfg_if.sink    cfg
);
	import arc_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// capacity writes are always accepted and also flush the lists and the target
	assign cfg.ready = 1'b1;

	// sequencer: search pass, then drop/evict/divide/demote/remove/push steps
	arc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// list storage, divider and result register
	arc_dp #(
		.MAX_PAGES (MAX_PAGES),
		.KEY_BITS  (KEY_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.page_key       (req.page_key),
		.cfg_we         (cfg.valid),
		.cfg_data       (cfg.capacity_in_use),
		.out_take       (rsp.valid && rsp.ready),
		.out_valid      (rsp.valid),
		.hit            (rsp.hit),
		.found_list     (rsp.found_list),
		.evicted_valid  (rsp.evicted_valid),
		.evicted_page   (rsp.evicted_page),
		.target_t1_size (rsp.target_t1_size),
		.resident_count (rsp.resident_count)
	);

	// target never exceeds the capacity
	a_p_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		stat.p <= stat.cap)
		else $error("target above capacity");

	// resident pages never exceed the capacity
	a_res_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(LEN_W + 1)'(stat.len[L_T1]) + (LEN_W + 1)'(stat.len[L_T2]) <= (LEN_W + 1)'(stat.cap))
		else $error("resident count above capacity");

	// hit flag agrees with the list code
	a_hit_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.hit == (rsp.found_list == FND_T1 || rsp.found_list == FND_T2)))
		else $error("hit flag disagrees with list code");

	// no eviction reported on a hit
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.hit) |-> !rsp.evicted_valid)
		else $error("eviction reported on a hit");

endmodule

// ===== rtl/arc_dp.sv =====
// arc_dp: list storage, search, divider, target and result registers
// depends on arc_pkg; driven by arc_ctrl through dp_cmd_t
module arc_dp #(
	parameter int MAX_PAGES = 16,
	parameter int KEY_BITS  = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  arc_pkg::dp_cmd_t           cmd,
	output arc_pkg::dp_stat_t          stat,
	input  logic [arc_pkg::KEY_W-1:0]  page_key,
	input  logic                       cfg_we,
	input  logic [arc_pkg::CAP_W-1:0]  cfg_data,
	input  logic                       out_take,
	output logic                       out_valid,
	output logic                       hit,
	output logic [2:0]                 found_list,
	output logic                       evicted_valid,
	output logic [arc_pkg::KEY_W-1:0]  evicted_page,
	output logic [arc_pkg::CAP_W-1:0]  target_t1_size,
	output logic [arc_pkg::CAP_W-1:0]  resident_count
);
	import arc_pkg::*;

	localparam int LW  = $clog2(MAX_PAGES + 1);
	localparam int IW  = $clog2(MAX_PAGES);
	localparam int SW  = LW + CAP_W + 1;
	localparam int MW  = (KEY_BITS > KEY_W) ? KEY_BITS : KEY_W;
	localparam int DCW = $clog2(LW + 1);

	logic [KEY_BITS-1:0] lst_q [NLIST][MAX_PAGES];
	logic [LW-1:0]       len_q [NLIST];
	logic [LW-1:0]       pos_q [NLIST];
	logic [NLIST-1:0]    fnd_q;
	logic [IW-1:0]       idx_q;
	logic [KEY_BITS-1:0] key_q, gone_q;
	logic                ev_q;
	logic [CAP_W-1:0]    p_q, cap_q;
	logic [LW:0]         rem_q;
	logic [LW-1:0]       quo_q, den_q;
	logic [DCW-1:0]      dcnt_q;

	logic                out_valid_q, hit_q, ev_out_q;
	found_t              found_q;
	logic [KEY_W-1:0]    page_out_q;
	logic [CAP_W-1:0]    p_out_q, res_out_q;

	logic [KEY_BITS-1:0] rd [NLIST];
	logic [LW-1:0]       lenm1 [NLIST];
	logic [NLIST-1:0]    push_en, rem_en, pop_en, hit_now;
	logic [KEY_BITS-1:0] push_dat [NLIST];
	logic [MW-1:0]       key_wide, gone_wide;
	logic [KEY_BITS-1:0] key_in;
	found_t              fcode;
	logic [LW-1:0]       num, den;
	logic [LW:0]         rsh;
	logic [SW-1:0]       p_sum, p_diff, res_sum;

	function automatic logic [CAP_W-1:0] clamp_cap(input logic [CAP_W-1:0] v);
		logic [CAP_W-1:0] c;
		c = v;
		if (c == '0)
			c = CAP_W'(1);
		if (SW'(c) > SW'(MAX_PAGES))
			c = CAP_W'(MAX_PAGES);
		return c;
	endfunction

	assign key_wide  = MW'(page_key);
	assign key_in    = key_wide[KEY_BITS-1:0];
	assign gone_wide = MW'(gone_q);

	// read port per list: search index or the LRU slot
	for (genvar l = 0; l < NLIST; l++) begin : g_rd
		assign lenm1[l] = len_q[l] - LW'(1);
		assign rd[l] = lst_q[l][(cmd.op == OP_SEARCH) ? idx_q : lenm1[l][IW-1:0]];
		assign hit_now[l] = !fnd_q[l] && (LW'(idx_q) < len_q[l]) && (rd[l] == key_q);
	end

	always_comb begin
		if (fnd_q[L_T1])
			fcode = FND_T1;
		else if (fnd_q[L_T2])
			fcode = FND_T2;
		else if (fnd_q[L_B1])
			fcode = FND_B1;
		else if (fnd_q[L_B2])
			fcode = FND_B2;
		else
			fcode = FND_NONE;
	end

	// list operation decode
	always_comb begin
		push_en = '0;
		rem_en  = '0;
		pop_en  = '0;
		for (int l = 0; l < NLIST; l++)
			push_dat[l] = key_q;
		case (cmd.op)
			OP_REMOVE: begin
				if (pos_q[cmd.lst] < len_q[cmd.lst])
					rem_en[cmd.lst] = 1'b1;
			end
			OP_PUSH_KEY: push_en[cmd.lst] = 1'b1;
			OP_DEMOTE_T1: begin
				if (len_q[L_T1] != '0) begin
					pop_en[L_T1]   = 1'b1;
					push_en[L_B1]  = 1'b1;
					push_dat[L_B1] = rd[L_T1];
				end
			end
			OP_DEMOTE_T2: begin
				if (len_q[L_T2] != '0) begin
					pop_en[L_T2]   = 1'b1;
					push_en[L_B2]  = 1'b1;
					push_dat[L_B2] = rd[L_T2];
				end
			end
			OP_DROP_LRU: begin
				if (len_q[cmd.lst] != '0)
					pop_en[cmd.lst] = 1'b1;
			end
			OP_EVICT_T1: begin
				if (len_q[L_T1] != '0)
					pop_en[L_T1] = 1'b1;
			end
			default: ;
		endcase
	end

	// list entries: shift toward LRU on push, toward MRU on remove
	for (genvar l = 0; l < NLIST; l++) begin : g_lst
		for (genvar j = 0; j < MAX_PAGES; j++) begin : g_ent
			always_ff @(posedge clk) begin
				if (push_en[l]) begin
					if (j == 0)
						lst_q[l][j] <= push_dat[l];
					else
						lst_q[l][j] <= lst_q[l][(j == 0) ? 0 : j - 1];
				end else if (rem_en[l] && (LW'(j) >= pos_q[l]) && (j < MAX_PAGES - 1)) begin
					lst_q[l][j] <= lst_q[l][(j < MAX_PAGES - 1) ? j + 1 : j];
				end
			end
		end
	end

	// divider operands
	always_comb begin
		if (cmd.lst == L_B2) begin
			num = len_q[L_B1];
			den = len_q[L_B2];
		end else begin
			num = len_q[L_B2];
			den = len_q[L_B1];
		end
		rsh     = {rem_q[LW-1:0], quo_q[LW-1]};
		p_sum   = SW'(p_q) + SW'(quo_q);
		p_diff  = SW'(p_q) - SW'(quo_q);
		res_sum = SW'(len_q[L_T1]) + SW'(len_q[L_T2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < NLIST; l++) begin
				len_q[l] <= '0;
				pos_q[l] <= '0;
			end
			fnd_q       <= '0;
			idx_q       <= '0;
			ev_q        <= 1'b0;
			p_q         <= '0;
			cap_q       <= clamp_cap(CAP_W'(16));
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (cfg_we) begin
			for (int l = 0; l < NLIST; l++)
				len_q[l] <= '0;
			p_q   <= '0;
			cap_q <= clamp_cap(cfg_data);
		end else begin
			for (int l = 0; l < NLIST; l++) begin
				if (pop_en[l] || rem_en[l])
					len_q[l] <= len_q[l] - LW'(1);
				else if (push_en[l])
					len_q[l] <= (len_q[l] >= LW'(MAX_PAGES)) ? LW'(MAX_PAGES) : len_q[l] + LW'(1);
				if (push_en[l] && pos_q[l] < LW'(MAX_PAGES))
					pos_q[l] <= pos_q[l] + LW'(1);
			end
			if (out_take)
				out_valid_q <= 1'b0;
			case (cmd.op)
				OP_LOAD: begin
					fnd_q <= '0;
					idx_q <= '0;
					ev_q  <= 1'b0;
				end
				OP_SEARCH: begin
					idx_q <= idx_q + IW'(1);
					for (int l = 0; l < NLIST; l++) begin
						if (hit_now[l]) begin
							fnd_q[l] <= 1'b1;
							pos_q[l] <= LW'(idx_q);
						end
					end
				end
				OP_DEMOTE_T1: if (len_q[L_T1] != '0) ev_q <= 1'b1;
				OP_DEMOTE_T2: if (len_q[L_T2] != '0) ev_q <= 1'b1;
				OP_EVICT_T1:  if (len_q[L_T1] != '0) ev_q <= 1'b1;
				OP_DIV_START: begin
					if (den != '0 && den < num)
						dcnt_q <= DCW'(LW);
					else
						dcnt_q <= '0;
				end
				OP_DIV_STEP: if (dcnt_q != '0) dcnt_q <= dcnt_q - DCW'(1);
				OP_P_UP:     p_q <= (p_sum > SW'(cap_q)) ? cap_q : p_sum[CAP_W-1:0];
				OP_P_DOWN:   p_q <= (SW'(quo_q) >= SW'(p_q)) ? '0 : p_diff[CAP_W-1:0];
				OP_RESULT:   out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				key_q  <= key_in;
				gone_q <= '0;
			end
			OP_DEMOTE_T1: if (len_q[L_T1] != '0) gone_q <= rd[L_T1];
			OP_DEMOTE_T2: if (len_q[L_T2] != '0) gone_q <= rd[L_T2];
			OP_EVICT_T1:  if (len_q[L_T1] != '0) gone_q <= rd[L_T1];
			OP_DIV_START: begin
				rem_q <= '0;
				den_q <= den;
				quo_q <= (den != '0 && den < num) ? num : LW'(1);
			end
			OP_DIV_STEP: begin
				if (dcnt_q != '0) begin
					if (rsh >= {1'b0, den_q}) begin
						rem_q <= rsh - {1'b0, den_q};
						quo_q <= {quo_q[LW-2:0], 1'b1};
					end else begin
						rem_q <= rsh;
						quo_q <= {quo_q[LW-2:0], 1'b0};
					end
				end
			end
			OP_RESULT: begin
				hit_q      <= (fcode == FND_T1) || (fcode == FND_T2);
				found_q    <= fcode;
				ev_out_q   <= ev_q;
				page_out_q <= ev_q ? gone_wide[KEY_W-1:0] : '0;
				p_out_q    <= p_q;
				res_out_q  <= res_sum[CAP_W-1:0];
			end
			default: ;
		endcase
	end

	always_comb begin
		for (int l = 0; l < NLIST; l++)
			stat.len[l] = LEN_W'(len_q[l]);
		stat.p           = p_q;
		stat.cap         = cap_q;
		stat.fcode       = fcode;
		stat.search_last = (idx_q == IW'(MAX_PAGES - 1));
		stat.div_busy    = (dcnt_q != '0);
		stat.out_busy    = out_valid_q;
	end

	assign out_valid      = out_valid_q;
	assign hit            = hit_q;
	assign found_list     = found_q;
	assign evicted_valid  = ev_out_q;
	assign evicted_page   = page_out_q;
	assign target_t1_size = p_out_q;
	assign resident_count = res_out_q;

endmodule

// ===== rtl/arc_ctrl.sv =====
// arc_ctrl: sequencer that walks one page request through the directory steps
// depends on arc_pkg; issues dp_cmd_t to arc_dp and reads dp_stat_t back
module arc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  arc_pkg::dp_stat_t  stat,
	output arc_pkg::dp_cmd_t   cmd
);
	import arc_pkg::*;

	localparam int SW = LEN_W + 2;

	ctrl_state_t state_q, nxt;
	logic [SW-1:0] t1, t2, b1, b2, l1, total, c1, c2, pp;
	logic from_t1;
	list_t ghost, flst;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= nxt;
	end

	always_comb begin
		t1    = SW'(stat.len[L_T1]);
		t2    = SW'(stat.len[L_T2]);
		b1    = SW'(stat.len[L_B1]);
		b2    = SW'(stat.len[L_B2]);
		l1    = t1 + b1;
		total = l1 + t2 + b2;
		c1    = SW'(stat.cap);
		c2    = c1 + c1;
		pp    = SW'(stat.p);
		ghost = (stat.fcode == FND_B2) ? L_B2 : L_B1;
		case (stat.fcode)
			FND_T1:  flst = L_T1;
			FND_T2:  flst = L_T2;
			FND_B1:  flst = L_B1;
			FND_B2:  flst = L_B2;
			default: flst = L_T1;
		endcase
		// replace: T1 if above target (or equal on a B2 hit), else T2; else any nonempty
		from_t1 = (t1 != '0) && ((t1 > pp) || ((stat.fcode == FND_B2) && (t1 == pp)));
		if (!from_t1 && t2 == '0)
			from_t1 = (t1 != '0);

		nxt      = state_q;
		in_ready = 1'b0;
		cmd.op   = OP_NONE;
		cmd.lst  = L_T1;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = OP_LOAD;
					nxt    = S_SEARCH;
				end
			end
			S_SEARCH: begin
				cmd.op = OP_SEARCH;
				if (stat.search_last)
					nxt = S_DECIDE;
			end
			S_DECIDE: begin
				case (stat.fcode)
					FND_T1, FND_T2: nxt = S_REMOVE;
					FND_B1, FND_B2: nxt = S_DIV_START;
					default: begin
						if (l1 == c1)
							nxt = (t1 < c1) ? S_DROP_B1 : S_EVICT;
						else if (l1 < c1 && total >= c1)
							nxt = (total >= c2) ? S_DROP_B2 : S_REPL;
						else
							nxt = S_PUSH;
					end
				endcase
			end
			S_DROP_B1: begin
				cmd.op  = OP_DROP_LRU;
				cmd.lst = L_B1;
				nxt     = S_REPL;
			end
			S_DROP_B2: begin
				cmd.op  = OP_DROP_LRU;
				cmd.lst = L_B2;
				nxt     = S_REPL;
			end
			S_EVICT: begin
				cmd.op = OP_EVICT_T1;
				nxt    = S_PUSH;
			end
			S_DIV_START: begin
				cmd.op  = OP_DIV_START;
				cmd.lst = ghost;
				nxt     = S_DIV;
			end
			S_DIV: begin
				cmd.op = OP_DIV_STEP;
				if (!stat.div_busy)
					nxt = S_PUPD;
			end
			S_PUPD: begin
				cmd.op = (stat.fcode == FND_B1) ? OP_P_UP : OP_P_DOWN;
				nxt    = S_REPL;
			end
			S_REPL: begin
				if (from_t1)
					cmd.op = OP_DEMOTE_T1;
				else if (t2 != '0)
					cmd.op = OP_DEMOTE_T2;
				nxt = (stat.fcode == FND_B1 || stat.fcode == FND_B2) ? S_REMOVE : S_PUSH;
			end
			S_REMOVE: begin
				cmd.op  = OP_REMOVE;
				cmd.lst = flst;
				nxt     = S_PUSH;
			end
			S_PUSH: begin
				cmd.op  = OP_PUSH_KEY;
				cmd.lst = (stat.fcode == FND_NONE) ? L_T1 : L_T2;
				nxt     = S_RESULT;
			end
			S_RESULT: begin
				if (!stat.out_busy) begin
					cmd.op = OP_RESULT;
					nxt    = S_IDLE;
				end
			end
			default: nxt = S_IDLE;
		endcase
	end

endmodule
